>>> sv/gmdp_pkg.sv
`default_nettype none

package gmdp_pkg;

  // Debounce window and pin geometry.
  localparam int WINDOW_SAMPLES = 5;
  localparam int PIN_COUNT      = 8;
  localparam int MAJORITY       = (WINDOW_SAMPLES + 1) / 2;
  localparam int POS_W          = (WINDOW_SAMPLES > 1) ? $clog2(WINDOW_SAMPLES) : 1;

  localparam logic [31:0] PIN_MASK_WIDE = ((32'd1 << PIN_COUNT) - 32'd1) & 32'h0000_00FF;
  localparam logic [7:0]  PIN_MASK      = PIN_MASK_WIDE[7:0];

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(WINDOW_SAMPLES - 1);

  // Pulse outputs.
  localparam int          OUT_COUNT       = 8;
  localparam logic [2:0]  PRE_PULSE_INDEX = 3'd2;
  localparam logic [15:0] ELAPSED_MAX     = 16'hFFFF;

  // Register reset values.
  localparam logic [15:0] PULSE_RESET   = 16'd50;
  localparam logic [7:0]  IN_SUP_RESET  = 8'hFF;
  localparam logic [7:0]  OUT_SUP_RESET = 8'hFF;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_PULSE_LENGTH     = 2'd0;
  localparam logic [1:0] REG_INPUT_SUPPORTED  = 2'd1;
  localparam logic [1:0] REG_OUTPUT_SUPPORTED = 2'd2;

  typedef enum logic [1:0] {
    ACT_TICK    = 2'd0,
    ACT_SAMPLE  = 2'd1,
    ACT_COMMAND = 2'd2,
    ACT_UNUSED  = 2'd3
  } action_e;

  typedef struct packed {
    logic [15:0] pulse_length;
    logic [7:0]  input_supported;
    logic [7:0]  output_supported;
  } cfg_t;

  // Per-item control from the command decoder to the debounce ring.
  typedef struct packed {
    logic [1:0] push_count;
    logic       decide;
    logic       set_override;
  } ring_ctrl_t;

  function automatic logic [POS_W-1:0] pos_inc(logic [POS_W-1:0] p);
    logic [POS_W-1:0] r;
    if (p >= LAST_POS) begin
      r = '0;
    end else begin
      r = p + POS_W'(1);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/gmdp_if.sv
`default_nettype none

interface gmdp_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] sample_bits;
  logic [2:0] out_pin;
  logic       turn_on;

  modport source (output valid, action, sample_bits, out_pin, turn_on, input ready);
  modport sink   (input valid, action, sample_bits, out_pin, turn_on, output ready);
endinterface

interface gmdp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] stable_inputs;
  logic [7:0] shown_inputs;
  logic [7:0] out_levels;
  logic [7:0] pending_off;
  logic       rejected;

  modport source (output valid, stable_inputs, shown_inputs, out_levels, pending_off,
                  rejected, input ready);
  modport sink   (input valid, stable_inputs, shown_inputs, out_levels, pending_off,
                  rejected, output ready);
endinterface

`default_nettype wire

>>> sv/gmdp_cfg.sv
`default_nettype none

module gmdp_cfg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [3:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic      [31:0]   prdata,
  output logic               pready,
  output gmdp_pkg::cfg_t     cfg_o
);

  gmdp_pkg::cfg_t cfg_q, cfg_d;
  logic           wr_en;
  logic [1:0]     reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        gmdp_pkg::REG_PULSE_LENGTH:     cfg_d.pulse_length     = pwdata[15:0];
        gmdp_pkg::REG_INPUT_SUPPORTED:  cfg_d.input_supported  = pwdata[7:0];
        gmdp_pkg::REG_OUTPUT_SUPPORTED: cfg_d.output_supported = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      gmdp_pkg::REG_PULSE_LENGTH:     prdata = {16'd0, cfg_q.pulse_length};
      gmdp_pkg::REG_INPUT_SUPPORTED:  prdata = {24'd0, cfg_q.input_supported};
      gmdp_pkg::REG_OUTPUT_SUPPORTED: prdata = {24'd0, cfg_q.output_supported};
      default:                        prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_length     <= gmdp_pkg::PULSE_RESET;
      cfg_q.input_supported  <= gmdp_pkg::IN_SUP_RESET;
      cfg_q.output_supported <= gmdp_pkg::OUT_SUP_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> sv/gmdp_pulse.sv
`default_nettype none

module gmdp_pulse (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [1:0]           action_i,
  input  wire logic [2:0]           out_pin_i,
  input  wire logic                 turn_on_i,
  input  wire gmdp_pkg::cfg_t       cfg_i,
  output gmdp_pkg::ring_ctrl_t      ctrl_o,
  output logic [7:0]                levels_d_o,
  output logic [7:0]                pending_d_o,
  output logic                      rejected_o
);

  logic [7:0]  levels_q, levels_d;
  logic [7:0]  pending_q, pending_d;
  logic [15:0] elapsed_q [gmdp_pkg::OUT_COUNT];
  logic [15:0] elapsed_d [gmdp_pkg::OUT_COUNT];

  logic [7:0]  pin_sel;
  logic        pin_ok;
  logic        pre_pulse;
  logic [15:0] inc;

  assign pin_sel   = 8'd1 << out_pin_i;
  assign pin_ok    = |(cfg_i.output_supported & pin_sel);
  // Switching on output 0 or 1 first pulses the pre-pulse output, if it exists.
  assign pre_pulse = turn_on_i && (out_pin_i == 3'd0 || out_pin_i == 3'd1) &&
                     cfg_i.output_supported[gmdp_pkg::PRE_PULSE_INDEX];

  always_comb begin
    levels_d   = levels_q;
    pending_d  = pending_q;
    elapsed_d  = elapsed_q;
    rejected_o = 1'b0;
    ctrl_o     = '0;
    inc        = '0;
    case (gmdp_pkg::action_e'(action_i))
      gmdp_pkg::ACT_TICK: begin
        for (int i = 0; i < gmdp_pkg::OUT_COUNT; i++) begin
          if (pending_q[i]) begin
            inc = (elapsed_q[i] == gmdp_pkg::ELAPSED_MAX) ? elapsed_q[i]
                                                          : elapsed_q[i] + 16'd1;
            elapsed_d[i] = inc;
            if (inc >= cfg_i.pulse_length) begin
              pending_d[i] = 1'b0;
              levels_d[i]  = 1'b0;
            end
          end
        end
      end
      gmdp_pkg::ACT_SAMPLE: begin
        ctrl_o.push_count = 2'd1;
        ctrl_o.decide     = 1'b1;
      end
      gmdp_pkg::ACT_COMMAND: begin
        if (!pin_ok) begin
          rejected_o = 1'b1;
        end else begin
          ctrl_o.decide       = 1'b1;
          ctrl_o.push_count   = pre_pulse ? 2'd3 : 2'd2;
          ctrl_o.set_override = pre_pulse ||
                                (turn_on_i && out_pin_i == gmdp_pkg::PRE_PULSE_INDEX);
          if (pre_pulse) begin
            levels_d[gmdp_pkg::PRE_PULSE_INDEX]  = 1'b1;
            pending_d[gmdp_pkg::PRE_PULSE_INDEX] = 1'b1;
            elapsed_d[gmdp_pkg::PRE_PULSE_INDEX] = '0;
          end
          if (turn_on_i) begin
            levels_d           = levels_d | pin_sel;
            pending_d          = pending_d | pin_sel;
            elapsed_d[out_pin_i] = '0;
          end else begin
            levels_d  = levels_d & ~pin_sel;
            pending_d = pending_d & ~pin_sel;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q  <= '0;
      pending_q <= '0;
      for (int i = 0; i < gmdp_pkg::OUT_COUNT; i++) begin
        elapsed_q[i] <= '0;
      end
    end else if (step_i) begin
      levels_q  <= levels_d;
      pending_q <= pending_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign levels_d_o  = levels_d;
  assign pending_d_o = pending_d;

endmodule

`default_nettype wire

>>> sv/gmdp_debounce.sv
`default_nettype none

module gmdp_debounce (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire gmdp_pkg::ring_ctrl_t ctrl_i,
  input  wire logic [7:0]           sample_bits_i,
  input  wire logic [7:0]           input_supported_i,
  output logic      [7:0]           stable_d_o,
  output logic                      override_d_o
);

  logic [7:0]                 ring_q [gmdp_pkg::WINDOW_SAMPLES];
  logic [7:0]                 ring_d [gmdp_pkg::WINDOW_SAMPLES];
  logic [gmdp_pkg::POS_W-1:0] pos_q, pos_d;
  logic [gmdp_pkg::POS_W-1:0] pos1, pos2, pos3;
  logic [7:0]                 stable_q, stable_d;
  logic                       override_q, override_d;
  logic [7:0]                 masked;
  logic [gmdp_pkg::WINDOW_SAMPLES-1:0] column;

  assign masked = sample_bits_i & input_supported_i & gmdp_pkg::PIN_MASK;
  assign pos1   = gmdp_pkg::pos_inc(pos_q);
  assign pos2   = gmdp_pkg::pos_inc(pos1);
  assign pos3   = gmdp_pkg::pos_inc(pos2);

  // A command pushes the same sample up to three times in a row.
  always_comb begin
    for (int k = 0; k < gmdp_pkg::WINDOW_SAMPLES; k++) begin
      if ((ctrl_i.push_count >= 2'd1 && pos_q == gmdp_pkg::POS_W'(k)) ||
          (ctrl_i.push_count >= 2'd2 && pos1  == gmdp_pkg::POS_W'(k)) ||
          (ctrl_i.push_count >= 2'd3 && pos2  == gmdp_pkg::POS_W'(k))) begin
        ring_d[k] = masked;
      end else begin
        ring_d[k] = ring_q[k];
      end
    end
    case (ctrl_i.push_count)
      2'd1:    pos_d = pos1;
      2'd2:    pos_d = pos2;
      2'd3:    pos_d = pos3;
      default: pos_d = pos_q;
    endcase
  end

  always_comb begin
    stable_d = stable_q;
    column   = '0;
    if (ctrl_i.decide) begin
      for (int i = 0; i < 8; i++) begin
        for (int k = 0; k < gmdp_pkg::WINDOW_SAMPLES; k++) begin
          column[k] = ring_d[k][i];
        end
        stable_d[i] = ($countones(column) >= gmdp_pkg::MAJORITY);
      end
    end
    override_d = (override_q | ctrl_i.set_override) & ~(ctrl_i.decide & ~stable_d[0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < gmdp_pkg::WINDOW_SAMPLES; k++) begin
        ring_q[k] <= '0;
      end
      pos_q      <= '0;
      stable_q   <= '0;
      override_q <= 1'b0;
    end else if (step_i) begin
      ring_q     <= ring_d;
      pos_q      <= pos_d;
      stable_q   <= stable_d;
      override_q <= override_d;
    end
  end

  assign stable_d_o   = stable_d;
  assign override_d_o = override_d;

endmodule

`default_nettype wire

>>> sv/gpio_majority_debounce_pulse_out_core.sv
`default_nettype none
// A result is loaded into the result register when its item advances out of the input
// register. Throughput: one item per cycle while the receiver takes each result; the
// input register and the result register together let a new item enter while the
// previous result waits to be taken.
// Reset (rst_ni low, asynchronous) clears the sample ring, stable levels, override,
// output levels and pulse counters, and loads the register reset values.

module gpio_majority_debounce_pulse_out_core (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  gmdp_in_if.sink     in_i,
  gmdp_out_if.source  out_o,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready
);

  gmdp_pkg::cfg_t       cfg;
  gmdp_pkg::ring_ctrl_t ring_ctrl;

  // Input register: holds one accepted item until the result register is free.
  logic       item_valid_q;
  logic [1:0] action_q;
  logic [7:0] sample_q;
  logic [2:0] pin_q;
  logic       on_q;

  // Result register.
  logic       res_valid_q;
  logic [7:0] res_stable_q, res_shown_q, res_levels_q, res_pending_q;
  logic       res_rejected_q;

  logic       advance;
  logic [7:0] stable_d, levels_d, pending_d;
  logic       override_d, rejected;

  // The held item moves on, and the block state is updated, whenever the result
  // register is empty or its transfer completes in this cycle.
  assign advance    = item_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready = !item_valid_q || advance;

  gmdp_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Command decode, output levels and pulse timers.
  gmdp_pulse u_pulse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .action_i    (action_q),
    .out_pin_i   (pin_q),
    .turn_on_i   (on_q),
    .cfg_i       (cfg),
    .ctrl_o      (ring_ctrl),
    .levels_d_o  (levels_d),
    .pending_d_o (pending_d),
    .rejected_o  (rejected)
  );

  // Sample ring, majority decision and the input 0 override.
  gmdp_debounce u_debounce (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .step_i            (advance),
    .ctrl_i            (ring_ctrl),
    .sample_bits_i     (sample_q),
    .input_supported_i (cfg.input_supported),
    .stable_d_o        (stable_d),
    .override_d_o      (override_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      if (in_i.ready) begin
        item_valid_q <= in_i.valid;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      action_q <= in_i.action;
      sample_q <= in_i.sample_bits;
      pin_q    <= in_i.out_pin;
      on_q     <= in_i.turn_on;
    end
    if (advance) begin
      res_stable_q   <= stable_d;
      res_shown_q    <= override_d ? (stable_d & 8'hFE) : stable_d;
      res_levels_q   <= levels_d;
      res_pending_q  <= pending_d;
      res_rejected_q <= rejected;
    end
  end

  assign out_o.valid         = res_valid_q;
  assign out_o.stable_inputs = res_stable_q;
  assign out_o.shown_inputs  = res_shown_q;
  assign out_o.out_levels    = res_levels_q;
  assign out_o.pending_off   = res_pending_q;
  assign out_o.rejected      = res_rejected_q;

endmodule

`default_nettype wire

>>> test/testbench.sv
`default_nettype none

module testbench;
  import gmdp_pkg::*;

  // One item for the debounce core: a tick, a pin sample or an output command.
  typedef struct packed {
    action_e    action;
    logic [7:0] sample_bits;
    logic [2:0] out_pin;
    logic       turn_on;
  } gpio_item_t;

  // The report the core returns for every item, showing its state afterwards.
  typedef struct packed {
    logic [7:0] stable_inputs;
    logic [7:0] shown_inputs;
    logic [7:0] out_levels;
    logic [7:0] pending_off;
    logic       rejected;
  } pin_report_t;

  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 230;
  localparam int HOLD_CYCLES = 200;
  localparam int MAX_REPORTS = 10;

  // Register settings and handshake idling for each random phase. The
  // settings include the extremes of every register, a zero pulse length,
  // and masks that leave the pre-pulse output or every output unsupported.
  int phase_pulse   [PHASES] = '{3, 1, 0, 65535, 7, 2, 12, 4};
  int phase_in_sup  [PHASES] = '{8'hFF, 8'h5A, 8'h00, 8'hFF, 8'hA5, 8'hFE, 8'h01, 8'hFF};
  int phase_out_sup [PHASES] = '{8'hFF, 8'hF3, 8'h00, 8'hFF, 8'h07, 8'hFC, 8'hFB, 8'hFF};
  int phase_send    [PHASES] = '{0, 52, 0, 11, 0, 52, 0, 11};
  int phase_recv    [PHASES] = '{0, 0, 52, 11, 0, 0, 52, 11};

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  gmdp_in_if  in_bus ();
  gmdp_out_if out_bus ();

  gpio_majority_debounce_pulse_out_core DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_bus),
    .out_o   (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Items waiting to be offered, and the reports the predictor expects back
  // in the order their items were transferred.
  gpio_item_t  pending_gpio_items [$];
  pin_report_t expected_pin_reports [$];
  gpio_item_t  offered_item;

  // Idling percentages for the current phase, and the long receiver hold-off.
  int send_idle_pct;
  int recv_stall_pct;
  int hold_requests;
  int hold_grants;
  int hold_left;

  int fail_count;
  int items_sent;
  int reports_checked;
  int rejected_seen;
  int override_seen;
  int phase_items;

  // Predictor state: a private copy of the registers and of the core state.
  cfg_t        model_cfg;
  logic [7:0]  sample_window [WINDOW_SAMPLES];
  int          window_pos;
  logic [7:0]  stable_levels;
  logic        show_override;
  logic [7:0]  output_levels;
  logic [7:0]  pulse_pending;
  logic [15:0] pulse_ticks [OUT_COUNT];

  pin_report_t got_report;
  pin_report_t want_report;

  // Writes one masked sample into the debounce window and advances the slot.
  function automatic void store_sample(logic [7:0] raw);
    sample_window[window_pos] = raw & model_cfg.input_supported & PIN_MASK;
    window_pos = (window_pos >= WINDOW_SAMPLES - 1) ? 0 : window_pos + 1;
  endfunction

  // Majority vote of every pin over the window. The override on input 0
  // lifts as soon as input 0 is decided low.
  function automatic void vote_levels();
    int ones;
    for (int pin = 0; pin < 8; pin++) begin
      ones = 0;
      for (int k = 0; k < WINDOW_SAMPLES; k++) begin
        ones += sample_window[k][pin];
      end
      stable_levels[pin] = (ones >= MAJORITY);
    end
    if (show_override && !stable_levels[0]) begin
      show_override = 1'b0;
    end
  endfunction

  // One output switch inside a command. An unsupported output is skipped
  // without any effect, which is how the pre-pulse drops out silently.
  function automatic void switch_output(logic [2:0] idx, logic on, logic [7:0] raw);
    if (!model_cfg.output_supported[idx]) begin
      return;
    end
    output_levels[idx] = on;
    store_sample(raw);
    if (idx == PRE_PULSE_INDEX && on) begin
      show_override = 1'b1;
    end
    pulse_pending[idx] = on;
    if (on) begin
      pulse_ticks[idx] = '0;
    end
  endfunction

  // Applies one item to the predictor state and returns the report the core
  // has to produce for it.
  function automatic pin_report_t advance_gpio_model(gpio_item_t it);
    pin_report_t rep;
    rep.rejected = 1'b0;
    case (it.action)
      ACT_TICK: begin
        for (int i = 0; i < OUT_COUNT; i++) begin
          if (pulse_pending[i]) begin
            if (pulse_ticks[i] != ELAPSED_MAX) begin
              pulse_ticks[i] = pulse_ticks[i] + 16'd1;
            end
            if (pulse_ticks[i] >= model_cfg.pulse_length) begin
              pulse_pending[i] = 1'b0;
              output_levels[i] = 1'b0;
            end
          end
        end
      end
      ACT_SAMPLE: begin
        store_sample(it.sample_bits);
        vote_levels();
      end
      ACT_COMMAND: begin
        if (!model_cfg.output_supported[it.out_pin]) begin
          rep.rejected = 1'b1;
        end else begin
          // Switching on output 0 or output 1 pulses output 2 first.
          if (it.turn_on && it.out_pin <= 3'd1) begin
            switch_output(PRE_PULSE_INDEX, 1'b1, it.sample_bits);
          end
          switch_output(it.out_pin, it.turn_on, it.sample_bits);
          store_sample(it.sample_bits);
          vote_levels();
        end
      end
      default: begin
        // The unused action code leaves everything as it was.
      end
    endcase
    rep.stable_inputs = stable_levels;
    rep.shown_inputs  = show_override ? (stable_levels & 8'hFE) : stable_levels;
    rep.out_levels    = output_levels;
    rep.pending_off   = pulse_pending;
    return rep;
  endfunction

  // Clock; reset is held by the main sequence and released once.
  initial begin
    clk_i = 1'b0;
    forever begin
      #5 clk_i = ~clk_i;
    end
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // Driver. An item stays on the bus until it is transferred; a transfer is
  // handed to the predictor at the edge it happens. A new item, or an idle
  // cycle, is chosen only when the bus is free.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        expected_pin_reports.push_back(advance_gpio_model(offered_item));
        items_sent++;
      end
      if (in_bus.valid && !in_bus.ready) begin
        // The item is held until the core takes it.
      end else if (pending_gpio_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        offered_item = pending_gpio_items.pop_front();
        in_bus.valid       <= 1'b1;
        in_bus.action      <= offered_item.action;
        in_bus.sample_bits <= offered_item.sample_bits;
        in_bus.out_pin     <= offered_item.out_pin;
        in_bus.turn_on     <= offered_item.turn_on;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end
  end

  // Long hold-off of the receiver. A request from the sequence starts a
  // countdown, during which the monitor keeps ready low.
  always @(posedge clk_i) begin
    if (hold_requests != hold_grants) begin
      hold_grants <= hold_requests;
      hold_left   <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor. Each report transfer is checked field by field against the
  // oldest expectation; the first few failures are printed in full.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got_report.stable_inputs = out_bus.stable_inputs;
        got_report.shown_inputs  = out_bus.shown_inputs;
        got_report.out_levels    = out_bus.out_levels;
        got_report.pending_off   = out_bus.pending_off;
        got_report.rejected      = out_bus.rejected;
        if (expected_pin_reports.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("unexpected report: stable %h shown %h out %h pending %h rejected %b",
                     got_report.stable_inputs, got_report.shown_inputs,
                     got_report.out_levels, got_report.pending_off, got_report.rejected);
          end
        end else begin
          want_report = expected_pin_reports.pop_front();
          reports_checked++;
          if (want_report.rejected) begin
            rejected_seen++;
          end
          if (want_report.shown_inputs != want_report.stable_inputs) begin
            override_seen++;
          end
          if (got_report.stable_inputs !== want_report.stable_inputs ||
              got_report.shown_inputs  !== want_report.shown_inputs  ||
              got_report.out_levels    !== want_report.out_levels    ||
              got_report.pending_off   !== want_report.pending_off   ||
              got_report.rejected      !== want_report.rejected) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS) begin
              $display("report %0d mismatch: stable %h/%h shown %h/%h out %h/%h",
                       reports_checked, want_report.stable_inputs, got_report.stable_inputs,
                       want_report.shown_inputs, got_report.shown_inputs,
                       want_report.out_levels, got_report.out_levels);
              $display("  pending %h/%h rejected %b/%b (expected/actual)",
                       want_report.pending_off, got_report.pending_off,
                       want_report.rejected, got_report.rejected);
            end
          end
        end
      end
      out_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Queues one item. Items of the unused action code do nothing in the core,
  // so they do not count toward the size of a phase.
  function automatic void queue_item(action_e act, logic [7:0] bits, logic [2:0] pin,
                                     logic on);
    gpio_item_t it;
    it.action      = act;
    it.sample_bits = bits;
    it.out_pin     = pin;
    it.turn_on     = on;
    pending_gpio_items.push_back(it);
    if (act != ACT_UNUSED) begin
      phase_items++;
    end
  endfunction

  // Random traffic built from short, meaningful runs: steady samples that
  // move the vote with the odd glitch, commands aimed mostly at the pins
  // tied to the pre-pulse, tick bursts around the pulse length, and noise.
  task automatic queue_random_phase(int count, int pulse);
    int         kind;
    int         runs;
    logic [7:0] level;
    logic [7:0] glitch;
    logic [2:0] pin;
    phase_items = 0;
    while (phase_items < count) begin
      kind = $urandom_range(99);
      if (kind < 40) begin
        level = 8'($urandom);
        runs  = $urandom_range(6, 3);
        repeat (runs) begin
          glitch = ($urandom_range(7) == 0) ? (8'h01 << $urandom_range(7)) : 8'h00;
          queue_item(ACT_SAMPLE, level ^ glitch, 3'($urandom), 1'($urandom));
        end
      end else if (kind < 65) begin
        pin = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(2));
        queue_item(ACT_COMMAND, 8'($urandom), pin, $urandom_range(3) != 0);
      end else if (kind < 90) begin
        runs = $urandom_range((pulse > 10) ? 12 : pulse + 2, 1);
        repeat (runs) begin
          queue_item(ACT_TICK, 8'($urandom), 3'($urandom), 1'($urandom));
        end
      end else begin
        queue_item(action_e'($urandom_range(3)), 8'($urandom), 3'($urandom),
                   1'($urandom));
      end
    end
  endtask

  // Register write: a setup cycle, then an access cycle that completes at
  // the edge where pready is seen high. The predictor follows the write.
  task automatic write_register(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PULSE_LENGTH:     model_cfg.pulse_length     = value[15:0];
      REG_INPUT_SUPPORTED:  model_cfg.input_supported  = value[7:0];
      REG_OUTPUT_SUPPORTED: model_cfg.output_supported = value[7:0];
      default: begin
      end
    endcase
  endtask

  // Waits until every queued item has been transferred and every expected
  // report has come back, then lets the pipeline settle.
  task automatic wait_until_idle();
    do begin
      @(negedge clk_i);
    end while (pending_gpio_items.size() != 0 || in_bus.valid ||
               expected_pin_reports.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  initial begin
    // Every input is known from time zero; reset is asserted at once.
    rst_ni              = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    in_bus.valid        = 1'b0;
    in_bus.action       = ACT_TICK;
    in_bus.sample_bits  = '0;
    in_bus.out_pin      = '0;
    in_bus.turn_on      = 1'b0;
    out_bus.ready       = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    hold_requests       = 0;
    hold_grants         = 0;
    hold_left           = 0;
    fail_count          = 0;
    items_sent          = 0;
    reports_checked     = 0;
    rejected_seen       = 0;
    override_seen       = 0;

    // The predictor starts from the state the core has after reset.
    model_cfg.pulse_length     = PULSE_RESET;
    model_cfg.input_supported  = IN_SUP_RESET;
    model_cfg.output_supported = OUT_SUP_RESET;
    for (int k = 0; k < WINDOW_SAMPLES; k++) begin
      sample_window[k] = '0;
    end
    for (int i = 0; i < OUT_COUNT; i++) begin
      pulse_ticks[i] = '0;
    end
    window_pos    = 0;
    stable_levels = '0;
    show_override = 1'b0;
    output_levels = '0;
    pulse_pending = '0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part with the reset register values: the vote rising to all
    // ones, commands on every output including both pre-pulse pins and the
    // pre-pulse pin itself, switch-offs, the override holding input 0 low
    // until input 0 is voted low, ticks, and the unused action code.
    queue_item(ACT_SAMPLE,  8'hFF, 3'd0, 1'b0);
    queue_item(ACT_SAMPLE,  8'hFF, 3'd7, 1'b1);
    queue_item(ACT_SAMPLE,  8'hFF, 3'd0, 1'b0);
    queue_item(ACT_COMMAND, 8'hFF, 3'd0, 1'b1);
    queue_item(ACT_COMMAND, 8'h01, 3'd1, 1'b1);
    queue_item(ACT_COMMAND, 8'h80, 3'd7, 1'b1);
    queue_item(ACT_COMMAND, 8'h00, 3'd7, 1'b0);
    queue_item(ACT_COMMAND, 8'h00, 3'd2, 1'b1);
    queue_item(ACT_COMMAND, 8'hAA, 3'd3, 1'b0);
    queue_item(ACT_TICK,    8'h55, 3'd5, 1'b1);
    queue_item(ACT_TICK,    8'hFF, 3'd7, 1'b1);
    queue_item(ACT_TICK,    8'h00, 3'd0, 1'b0);
    queue_item(ACT_UNUSED,  8'hAA, 3'd5, 1'b1);
    queue_item(ACT_SAMPLE,  8'h00, 3'd0, 1'b0);
    queue_item(ACT_SAMPLE,  8'h00, 3'd0, 1'b0);
    queue_item(ACT_SAMPLE,  8'h00, 3'd0, 1'b0);
    queue_item(ACT_SAMPLE,  8'h80, 3'd0, 1'b0);
    queue_item(ACT_SAMPLE,  8'h7F, 3'd0, 1'b0);
    queue_item(ACT_COMMAND, 8'hFF, 3'd6, 1'b1);
    queue_item(ACT_COMMAND, 8'h00, 3'd4, 1'b1);
    queue_item(ACT_COMMAND, 8'h0F, 3'd5, 1'b0);
    queue_item(ACT_TICK,    8'h00, 3'd0, 1'b0);

    // Random phases, each under its own register setting and idling mix.
    // Registers change only once the core has returned every report.
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_until_idle();
      write_register(REG_PULSE_LENGTH,     32'(phase_pulse[ph]));
      write_register(REG_INPUT_SUPPORTED,  32'(phase_in_sup[ph]));
      write_register(REG_OUTPUT_SUPPORTED, 32'(phase_out_sup[ph]));
      @(negedge clk_i);
      send_idle_pct  = phase_send[ph];
      recv_stall_pct = phase_recv[ph];
      queue_random_phase(PHASE_ITEMS, phase_pulse[ph]);
      // In one phase the receiver stops for a long stretch while the sender
      // keeps offering, so the core fills up and pushes back on its input.
      if (ph == 3) begin
        hold_requests = hold_requests + 1;
      end
    end

    wait_until_idle();
    repeat (10) @(posedge clk_i);
    fail_count += expected_pin_reports.size();

    $display("covered %0d items in %0d register settings, %0d reports checked",
             items_sent, PHASES + 1, reports_checked);
    $display("  %0d rejected commands, %0d reports with input 0 held off",
             rejected_seen, override_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
